@@ rtl/issue_queue_wakeup_select_defines.svh @@
// ----------------------------------------------------------------------------
// Issue queue assertion macros
// Shared property shorthands for the issue queue checks.
// ----------------------------------------------------------------------------
`ifndef ISSUE_QUEUE_WAKEUP_SELECT_DEFINES_SVH
`define ISSUE_QUEUE_WAKEUP_SELECT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define IQWS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define IQWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/iqws_pkg.sv @@
// ----------------------------------------------------------------------------
// Issue queue package
// Function codes, broadcast item and chain carry types, latency table.
// ----------------------------------------------------------------------------
package iqws_pkg;

	localparam int TAG_W = 10;
	localparam int OP_W  = 2;
	localparam int PC_W  = 32;
	localparam int AGE_W = 32;
	localparam int LAT_W = 3;
	localparam int FN_W  = 2;

	typedef enum logic [FN_W-1:0] {
		FUNC_DISPATCH = 2'd0,
		FUNC_WAKEUP   = 2'd1,
		FUNC_SELECT   = 2'd2,
		FUNC_NOP      = 2'd3
	} func_t;

	typedef enum logic [OP_W-1:0] {
		OP_CLASS_0 = 2'd0,
		OP_CLASS_1 = 2'd1,
		OP_CLASS_2 = 2'd2,
		OP_CLASS_3 = 2'd3
	} op_class_t;

	// item held at the top and seen by every cell during a sweep
	typedef struct packed {
		func_t            func;
		logic [TAG_W-1:0] dest;
		logic [TAG_W-1:0] src1;
		logic             src1_rdy;
		logic [TAG_W-1:0] src2;
		logic             src2_rdy;
		logic [OP_W-1:0]  op;
		logic [PC_W-1:0]  pc;
		logic [TAG_W-1:0] wake_tag;
		logic [AGE_W-1:0] age;
	} item_t;

	// handed from cell to cell
	typedef struct packed {
		logic             tok;
		logic             placed;
		logic             found;
		logic [TAG_W-1:0] dest;
		logic [TAG_W-1:0] src1;
		logic [TAG_W-1:0] src2;
		logic [OP_W-1:0]  op;
		logic [PC_W-1:0]  pc;
		logic [AGE_W-1:0] age;
	} carry_t;

	function automatic logic [LAT_W-1:0] exec_lat(input logic [OP_W-1:0] op);
		logic [LAT_W-1:0] lat;
		case (op_class_t'(op))
			OP_CLASS_0: lat = 3'd1;
			OP_CLASS_1: lat = 3'd2;
			OP_CLASS_2: lat = 3'd5;
			default:    lat = 3'd0;
		endcase
		return lat;
	endfunction

	// wrap-aware age order: a older than b
	function automatic logic older(input logic [AGE_W-1:0] a, input logic [AGE_W-1:0] b);
		logic [AGE_W-1:0] d;
		d = a - b;
		return d[AGE_W-1];
	endfunction

endpackage

@@ rtl/iqws_cell.sv @@
// ----------------------------------------------------------------------------
// Issue queue cell
// One queue slot; acts on the item when the sweep token passes through.
// ----------------------------------------------------------------------------
module iqws_cell import iqws_pkg::*; #(
	parameter int IDX_W    = 5,
	parameter int CNT_W    = 6,
	parameter int CELL_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            item,
	input  carry_t           carry_in,
	input  logic [IDX_W-1:0] idx_in,
	input  logic [CNT_W-1:0] nfree_in,
	input  logic [CNT_W-1:0] nready_in,
	input  logic             kill_en,
	input  logic [IDX_W-1:0] kill_idx,
	output carry_t           carry_out,
	output logic [IDX_W-1:0] idx_out,
	output logic [CNT_W-1:0] nfree_out,
	output logic [CNT_W-1:0] nready_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic             valid_q;
	logic [TAG_W-1:0] dest_q;
	logic [TAG_W-1:0] src1_q;
	logic             r1_q;
	logic [TAG_W-1:0] src2_q;
	logic             r2_q;
	logic [OP_W-1:0]  op_q;
	logic [PC_W-1:0]  pc_q;
	logic [AGE_W-1:0] age_q;

	logic             tok_q;
	carry_t           carry_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] nfree_q;
	logic [CNT_W-1:0] nready_q;

	logic claim, wake, hit1, hit2, take, kill_hit;
	logic nv, nr1, nr2;

	carry_t           carry_nx;
	logic [IDX_W-1:0] idx_nx;

	always_comb begin
		claim    = carry_in.tok && (item.func == FUNC_DISPATCH) && !valid_q && !carry_in.placed;
		wake     = carry_in.tok && (item.func == FUNC_WAKEUP) && valid_q;
		hit1     = wake && (src1_q == item.wake_tag);
		hit2     = wake && (src2_q == item.wake_tag);
		take     = carry_in.tok && (item.func == FUNC_SELECT) && valid_q && r1_q && r2_q
			&& (!carry_in.found || older(age_q, carry_in.age));
		kill_hit = kill_en && (kill_idx == MY_IDX);
		// post-item state, for the running counts
		nv  = claim || valid_q;
		nr1 = claim ? item.src1_rdy : (r1_q || hit1);
		nr2 = claim ? item.src2_rdy : (r2_q || hit2);
	end

	// carry handed to the next cell
	always_comb begin
		carry_nx        = carry_in;
		carry_nx.placed = carry_in.placed || claim;
		carry_nx.found  = carry_in.found || take;
		idx_nx          = idx_in;
		if (take) begin
			carry_nx.dest = dest_q;
			carry_nx.src1 = src1_q;
			carry_nx.src2 = src2_q;
			carry_nx.op   = op_q;
			carry_nx.pc   = pc_q;
			carry_nx.age  = age_q;
			idx_nx        = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= carry_in.tok;
			if (claim) begin
				valid_q <= 1'b1;
			end else if (kill_hit) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			dest_q <= item.dest;
			src1_q <= item.src1;
			src2_q <= item.src2;
			op_q   <= item.op;
			pc_q   <= item.pc;
			age_q  <= item.age;
		end
		r1_q <= nr1;
		r2_q <= nr2;
		if (carry_in.tok) begin
			carry_q  <= carry_nx;
			idx_q    <= idx_nx;
			nfree_q  <= nfree_in + (nv ? '0 : CNT_W'(1));
			nready_q <= nready_in + ((nv && nr1 && nr2) ? CNT_W'(1) : '0);
		end
	end

	always_comb begin
		carry_out     = carry_q;
		carry_out.tok = tok_q;
	end

	assign idx_out    = idx_q;
	assign nfree_out  = nfree_q;
	assign nready_out = nready_q;

endmodule

@@ rtl/issue_queue_wakeup_select.sv @@
// ----------------------------------------------------------------------------
// Issue queue with wakeup and oldest-first select
// Row of slot cells swept by a token; dispatch, wakeup and select per item.
// ----------------------------------------------------------------------------
// Flow: an accepted item is registered and launches a token that passes
//   through each cell in turn; at the end of the row the sweep closes into
//   the pending register, then the result moves into the output register.
// One item is in flight at a time: a new item is taken only after the last
//   result has moved into the output register, also while it still waits there.
// Reset: all slots invalid, age counter zero; slot payload is not cleared.
module issue_queue_wakeup_select import iqws_pkg::*; #(
	parameter int IQ_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [9:0]  dest_tag,
	input  logic [9:0]  src1_tag,
	input  logic        src1_ready,
	input  logic [9:0]  src2_tag,
	input  logic        src2_ready,
	input  logic [1:0]  op_type,
	input  logic [31:0] instr_pc,
	input  logic [9:0]  wake_tag,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [9:0]  out_dest,
	output logic [9:0]  out_src1,
	output logic [9:0]  out_src2,
	output logic [1:0]  out_op_type,
	output logic [31:0] out_pc,
	output logic [2:0]  exec_latency,
	output logic [5:0]  free_slots,
	output logic [5:0]  ready_slots
);

	localparam int IDX_W = (IQ_DEPTH > 1) ? $clog2(IQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(IQ_DEPTH + 1);
	localparam int SAT   = 63;

	// one result item
	typedef struct packed {
		logic             acc;
		logic [TAG_W-1:0] dest;
		logic [TAG_W-1:0] src1;
		logic [TAG_W-1:0] src2;
		logic [OP_W-1:0]  op;
		logic [PC_W-1:0]  pc;
		logic [LAT_W-1:0] lat;
		logic [5:0]       nfree;
		logic [5:0]       nready;
	} res_t;

	logic             busy_q;    // item in flight until its result is in the output register
	logic             start_q;   // launches the token into cell 0
	logic             pend_q;    // sweep done, result waiting for the output register
	logic             out_valid_q;
	logic [AGE_W-1:0] age_ctr_q;

	item_t item_q;
	res_t  pend_res_q;
	res_t  out_res_q;
	res_t  res_c;

	logic in_xfer;

	// chain wiring
	carry_t           carry_w  [IQ_DEPTH+1];
	logic [IDX_W-1:0] idx_w    [IQ_DEPTH+1];
	logic [CNT_W-1:0] nfree_w  [IQ_DEPTH+1];
	logic [CNT_W-1:0] nready_w [IQ_DEPTH+1];
	logic [IQ_DEPTH-1:0] tok_vec;

	carry_t           end_c;
	logic             last_tok;
	logic             issued;
	logic             kill_en;
	logic [CNT_W-1:0] free_adj;
	logic [CNT_W-1:0] ready_adj;

	assign in_stall = busy_q;
	assign in_xfer  = in_valid && !busy_q;

	always_comb begin
		carry_w[0]     = '0;
		carry_w[0].tok = start_q;
		idx_w[0]       = '0;
		nfree_w[0]     = '0;
		nready_w[0]    = '0;
	end

	for (genvar g = 0; g < IQ_DEPTH; g++) begin : g_cell
		iqws_cell #(
			.IDX_W    (IDX_W),
			.CNT_W    (CNT_W),
			.CELL_IDX (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.item       (item_q),
			.carry_in   (carry_w[g]),
			.idx_in     (idx_w[g]),
			.nfree_in   (nfree_w[g]),
			.nready_in  (nready_w[g]),
			.kill_en    (kill_en),
			.kill_idx   (idx_w[IQ_DEPTH]),
			.carry_out  (carry_w[g+1]),
			.idx_out    (idx_w[g+1]),
			.nfree_out  (nfree_w[g+1]),
			.nready_out (nready_w[g+1])
		);
		assign tok_vec[g] = carry_w[g+1].tok;
	end

	// close the sweep: the chosen entry is removed by a kill broadcast, so
	// the counts from the row are corrected for it here
	always_comb begin
		end_c     = carry_w[IQ_DEPTH];
		last_tok  = end_c.tok;
		issued    = (item_q.func == FUNC_SELECT) && end_c.found;
		kill_en   = last_tok && issued;
		free_adj  = nfree_w[IQ_DEPTH] + (issued ? CNT_W'(1) : '0);
		ready_adj = nready_w[IQ_DEPTH] - (issued ? CNT_W'(1) : '0);

		res_c        = '0;
		res_c.acc    = ((item_q.func == FUNC_DISPATCH) && end_c.placed) || issued;
		if (issued) begin
			res_c.dest = end_c.dest;
			res_c.src1 = end_c.src1;
			res_c.src2 = end_c.src2;
			res_c.op   = end_c.op;
			res_c.pc   = end_c.pc;
			res_c.lat  = exec_lat(end_c.op);
		end
		res_c.nfree  = (32'(free_adj) > SAT) ? 6'(SAT) : 6'(free_adj);
		res_c.nready = (32'(ready_adj) > SAT) ? 6'(SAT) : 6'(ready_adj);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			age_ctr_q   <= '0;
		end else begin
			start_q <= in_xfer;
			if (in_xfer) begin
				busy_q <= 1'b1;
			end
			if (last_tok) begin
				pend_q <= 1'b1;
				if ((item_q.func == FUNC_DISPATCH) && end_c.placed) begin
					age_ctr_q <= age_ctr_q + AGE_W'(1);
				end
			end
			if (pend_q && (!out_valid_q || !out_stall)) begin
				pend_q      <= 1'b0;
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_q.func     <= func_t'(func);
			item_q.dest     <= dest_tag;
			item_q.src1     <= src1_tag;
			item_q.src1_rdy <= src1_ready;
			item_q.src2     <= src2_tag;
			item_q.src2_rdy <= src2_ready;
			item_q.op       <= op_type;
			item_q.pc       <= instr_pc;
			item_q.wake_tag <= wake_tag;
			item_q.age      <= age_ctr_q;
		end
		if (last_tok) begin
			pend_res_q <= res_c;
		end
		if (pend_q && (!out_valid_q || !out_stall)) begin
			out_res_q <= pend_res_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = out_res_q.acc;
	assign out_dest     = out_res_q.dest;
	assign out_src1     = out_res_q.src1;
	assign out_src2     = out_res_q.src2;
	assign out_op_type  = out_res_q.op;
	assign out_pc       = out_res_q.pc;
	assign exec_latency = out_res_q.lat;
	assign free_slots   = out_res_q.nfree;
	assign ready_slots  = out_res_q.nready;

`include "issue_queue_wakeup_select_defines.svh"

	`IQWS_ASSERT_NEXT(a_xfer_busy, in_xfer, busy_q && start_q, "transfer did not launch a sweep")
	`IQWS_ASSERT_NOW(a_one_token, 1'b1, $onehot0({tok_vec, start_q}), "more than one sweep token")
	`IQWS_ASSERT_NOW(a_sweep_end, last_tok, busy_q && !pend_q, "sweep ended with a result pending")
	`IQWS_ASSERT_NOW(a_pend_busy, pend_q, busy_q, "pending result while not busy")

endmodule
